[sv/pkeq_pkg.sv]
// Shared types and constants for the peaking EQ biquad filter.
`timescale 1ns / 1ps
`default_nettype none

package pkeq_pkg;

   localparam int COEF_WIDTH    = 32;
   localparam int GUARD_BITS    = 8;
   localparam int CSR_ADDR_WIDTH = 5;
   localparam int CSR_DATA_WIDTH = 32;
   localparam int REG_IDX_WIDTH = 3;

   localparam logic [REG_IDX_WIDTH-1:0] REG_COEF_B0 = 3'd0;
   localparam logic [REG_IDX_WIDTH-1:0] REG_COEF_B1 = 3'd1;
   localparam logic [REG_IDX_WIDTH-1:0] REG_COEF_B2 = 3'd2;
   localparam logic [REG_IDX_WIDTH-1:0] REG_COEF_A1 = 3'd3;
   localparam logic [REG_IDX_WIDTH-1:0] REG_COEF_A2 = 3'd4;

   typedef logic [COEF_WIDTH-1:0] coef_word_type;

   typedef struct packed {
      coef_word_type b0;
      coef_word_type b1;
      coef_word_type b2;
      coef_word_type a1;
      coef_word_type a2;
   } coef_set_type;

   typedef enum logic [2:0] {
      MUL_B0,
      MUL_B1,
      MUL_B2,
      MUL_A1,
      MUL_A2
   } mul_sel_type;

   typedef struct packed {
      logic        load_in;
      mul_sel_type mul_sel;
      logic        do_acc;
      logic        do_rnd;
      logic        do_t2;
      logic        do_fb1;
      logic        do_fb2;
      logic        do_wb;
   } cmd_type;

endpackage

`default_nettype wire

[sv/pkeq_csr.sv]
// Coefficient register file behind the APB-style configuration port.
`timescale 1ns / 1ps
`default_nettype none

module pkeq_csr
   import pkeq_pkg::*;
#(
   parameter int COEF_FRAC_BITS = 26
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      csr_psel,
   input  wire logic                      csr_penable,
   input  wire logic                      csr_pwrite,
   input  wire logic [CSR_ADDR_WIDTH-1:0] csr_paddr,
   input  wire logic [CSR_DATA_WIDTH-1:0] csr_pwdata,
   output logic      [CSR_DATA_WIDTH-1:0] csr_prdata,
   output logic                           csr_pready,
   output coef_set_type                   coefs
);

   localparam coef_word_type COEF_UNITY =
      {{(COEF_WIDTH-1-COEF_FRAC_BITS){1'b0}}, 1'b1, {COEF_FRAC_BITS{1'b0}}};

   coef_set_type coef_ff;
   coef_set_type coef_in;
   logic [REG_IDX_WIDTH-1:0] reg_idx;
   logic write_en;

   assign csr_pready = 1'b1;
   assign reg_idx    = csr_paddr[CSR_ADDR_WIDTH-1:2];
   assign write_en   = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_comb begin
      coef_in = coef_ff;
      if (write_en) begin
         case (reg_idx)
            REG_COEF_B0: coef_in.b0 = csr_pwdata;
            REG_COEF_B1: coef_in.b1 = csr_pwdata;
            REG_COEF_B2: coef_in.b2 = csr_pwdata;
            REG_COEF_A1: coef_in.a1 = csr_pwdata;
            REG_COEF_A2: coef_in.a2 = csr_pwdata;
            default: coef_in = coef_ff;
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         REG_COEF_B0: csr_prdata = coef_ff.b0;
         REG_COEF_B1: csr_prdata = coef_ff.b1;
         REG_COEF_B2: csr_prdata = coef_ff.b2;
         REG_COEF_A1: csr_prdata = coef_ff.a1;
         REG_COEF_A2: csr_prdata = coef_ff.a2;
         default: csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_ff.b0 <= COEF_UNITY;
         coef_ff.b1 <= '0;
         coef_ff.b2 <= '0;
         coef_ff.a1 <= '0;
         coef_ff.a2 <= '0;
      end else begin
         coef_ff <= coef_in;
      end
   end

   assign coefs = coef_ff;

endmodule

`default_nettype wire

[sv/pkeq_ctrl.sv]
// Sequencer that steps one item through the shared multiplier schedule.
`timescale 1ns / 1ps
`default_nettype none

module pkeq_ctrl
   import pkeq_pkg::*;
(
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic req_valid,
   output logic      req_stall,
   output logic      rsp_valid,
   input  wire logic rsp_stall,
   output cmd_type   cmd
);

   typedef enum logic [7:0] {
      ST_IDLE = 8'b0000_0001,
      ST_MB0  = 8'b0000_0010,
      ST_ACC  = 8'b0000_0100,
      ST_RND  = 8'b0000_1000,
      ST_T2   = 8'b0001_0000,
      ST_FB1  = 8'b0010_0000,
      ST_FB2  = 8'b0100_0000,
      ST_WB   = 8'b1000_0000
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic rsp_valid_ff;
   logic rsp_valid_in;
   logic out_free;

   assign out_free = ~rsp_valid_ff | ~rsp_stall;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      cmd          = '0;
      cmd.mul_sel  = MUL_B0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load_in = 1'b1;
               state_in    = ST_MB0;
            end
         end
         ST_MB0: begin
            cmd.mul_sel = MUL_B0;
            state_in    = ST_ACC;
         end
         ST_ACC: begin
            cmd.do_acc  = 1'b1;
            cmd.mul_sel = MUL_B1;
            state_in    = ST_RND;
         end
         ST_RND: begin
            cmd.do_rnd  = 1'b1;
            cmd.mul_sel = MUL_B2;
            state_in    = ST_T2;
         end
         ST_T2: begin
            cmd.do_t2   = 1'b1;
            cmd.mul_sel = MUL_A1;
            state_in    = ST_FB1;
         end
         ST_FB1: begin
            cmd.do_fb1  = 1'b1;
            cmd.mul_sel = MUL_A2;
            state_in    = ST_FB2;
         end
         ST_FB2: begin
            cmd.do_fb2 = 1'b1;
            state_in   = ST_WB;
         end
         ST_WB: begin
            if (out_free) begin
               cmd.do_wb    = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

[sv/pkeq_dp.sv]
// Datapath: shared multiplier, accumulators, delay state and output register.
`timescale 1ns / 1ps
`default_nettype none

module pkeq_dp
   import pkeq_pkg::*;
#(
   parameter int SAMPLE_WIDTH   = 24,
   parameter int COEF_FRAC_BITS = 26,
   parameter int STATE_WIDTH    = 48
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire cmd_type                 cmd,
   input  wire coef_set_type            coefs,
   input  wire logic [SAMPLE_WIDTH-1:0] req_sample_in,
   input  wire logic                    req_block_end,
   output logic      [SAMPLE_WIDTH-1:0] rsp_sample_out,
   output logic                         rsp_block_end_out
);

   localparam int SW = SAMPLE_WIDTH;
   localparam int ST = STATE_WIDTH;
   localparam int PROD_SHIFT = COEF_FRAC_BITS - GUARD_BITS;
   localparam int MW = COEF_WIDTH + SW;
   localparam int PW = MW - PROD_SHIFT;
   localparam int AW = ((PW + 1 > ST) ? PW + 1 : ST) + 1;
   localparam int QW = ST + 1 - GUARD_BITS;
   localparam int RW = ((QW > SW) ? QW : SW) + 1;
   localparam logic [ST:0] RND_HALF =
      {{(ST+1-GUARD_BITS){1'b0}}, 1'b1, {(GUARD_BITS-1){1'b0}}};

   function automatic logic [ST-1:0] sat_state(input logic [AW-1:0] v);
      logic [AW-ST:0] top;
      top = v[AW-1:ST-1];
      if ((&top) || ~(|top)) begin
         return v[ST-1:0];
      end else if (v[AW-1]) begin
         return {1'b1, {(ST-1){1'b0}}};
      end else begin
         return {1'b0, {(ST-1){1'b1}}};
      end
   endfunction

   logic [SW-1:0] x_ff, x_in;
   logic          last_ff, last_in;
   logic [SW-1:0] y_ff, y_in;
   logic [MW-1:0] prod_ff, prod_in;
   logic [AW-1:0] acc_ff, acc_in;
   logic [AW-1:0] t2_ff, t2_in;
   logic [ST-1:0] d1_ff, d1_in;
   logic [ST-1:0] d2_ff, d2_in;
   logic [SW-1:0] out_sample_ff, out_sample_in;
   logic          out_last_ff, out_last_in;

   logic signed [COEF_WIDTH-1:0] coef_sel;
   logic signed [SW-1:0]         op_sel;
   logic signed [MW-1:0]         prod_full;
   logic [PW-1:0]  p_term;
   logic [AW-1:0]  p_ext;
   logic [AW-1:0]  d1_ext;
   logic [AW-1:0]  d2_ext;
   logic [ST-1:0]  acc_sat;
   logic [ST-1:0]  d1_sat;
   logic [ST-1:0]  d2_sat;
   logic [ST-1:0]  acc_st;
   logic [ST:0]    rnd_sum;
   logic [RW-1:0]  rnd_ext;
   logic [RW-SW:0] rnd_top;
   logic [SW-1:0]  y_sat;

   always_comb begin
      case (cmd.mul_sel)
         MUL_B0: coef_sel = coefs.b0;
         MUL_B1: coef_sel = coefs.b1;
         MUL_B2: coef_sel = coefs.b2;
         MUL_A1: coef_sel = coefs.a1;
         MUL_A2: coef_sel = coefs.a2;
         default: coef_sel = coefs.b0;
      endcase
   end

   assign op_sel    = (cmd.mul_sel == MUL_A1 || cmd.mul_sel == MUL_A2) ? y_ff : x_ff;
   assign prod_full = coef_sel * op_sel;
   assign prod_in   = prod_full;

   assign p_term = prod_ff[MW-1:PROD_SHIFT];
   assign p_ext  = {{(AW-PW){p_term[PW-1]}}, p_term};
   assign d1_ext = {{(AW-ST){d1_ff[ST-1]}}, d1_ff};
   assign d2_ext = {{(AW-ST){d2_ff[ST-1]}}, d2_ff};

   assign acc_sat = sat_state(p_ext + d1_ext);
   assign d1_sat  = sat_state(acc_ff + d2_ext);
   assign d2_sat  = sat_state(t2_ff);

   assign acc_st  = acc_ff[ST-1:0];
   assign rnd_sum = {acc_st[ST-1], acc_st} + RND_HALF;
   assign rnd_ext = {{(RW-QW){rnd_sum[ST]}}, rnd_sum[ST:GUARD_BITS]};
   assign rnd_top = rnd_ext[RW-1:SW-1];

   always_comb begin
      if ((&rnd_top) || ~(|rnd_top)) begin
         y_sat = rnd_ext[SW-1:0];
      end else if (rnd_ext[RW-1]) begin
         y_sat = {1'b1, {(SW-1){1'b0}}};
      end else begin
         y_sat = {1'b0, {(SW-1){1'b1}}};
      end
   end

   always_comb begin
      x_in          = x_ff;
      last_in       = last_ff;
      y_in          = y_ff;
      acc_in        = acc_ff;
      t2_in         = t2_ff;
      d1_in         = d1_ff;
      d2_in         = d2_ff;
      out_sample_in = out_sample_ff;
      out_last_in   = out_last_ff;
      if (cmd.load_in) begin
         x_in    = req_sample_in;
         last_in = req_block_end;
      end
      if (cmd.do_acc) begin
         acc_in = {{(AW-ST){acc_sat[ST-1]}}, acc_sat};
      end
      if (cmd.do_rnd) begin
         y_in   = y_sat;
         acc_in = p_ext;
      end
      if (cmd.do_t2) begin
         t2_in = p_ext;
      end
      if (cmd.do_fb1) begin
         acc_in = acc_ff - p_ext;
      end
      if (cmd.do_fb2) begin
         t2_in = t2_ff - p_ext;
      end
      if (cmd.do_wb) begin
         d1_in         = last_ff ? '0 : d1_sat;
         d2_in         = last_ff ? '0 : d2_sat;
         out_sample_in = y_ff;
         out_last_in   = last_ff;
      end
   end

   always_ff @(posedge clock) begin
      x_ff          <= x_in;
      last_ff       <= last_in;
      y_ff          <= y_in;
      prod_ff       <= prod_in;
      acc_ff        <= acc_in;
      t2_ff         <= t2_in;
      out_sample_ff <= out_sample_in;
      out_last_ff   <= out_last_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         d1_ff <= '0;
         d2_ff <= '0;
      end else begin
         d1_ff <= d1_in;
         d2_ff <= d2_in;
      end
   end

   assign rsp_sample_out    = out_sample_ff;
   assign rsp_block_end_out = out_last_ff;

endmodule

`default_nettype wire

[sv/peaking_eq_biquad_filter.sv]
// Peaking EQ biquad (transposed direct form II) with one shared multiplier.
// An item steps through states MB0, ACC, RND, T2, FB1, FB2, WB; WB waits while the output stalls.
// A new item is taken only when idle, as the five products go through one multiplier.
// Reset clears delay state, sequencer and output valid; b0 returns to unity and the rest to zero.
`timescale 1ns / 1ps
`default_nettype none

module peaking_eq_biquad_filter
   import pkeq_pkg::*;
#(
   parameter int SAMPLE_WIDTH   = 24,
   parameter int COEF_FRAC_BITS = 26,
   parameter int STATE_WIDTH    = 48
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   output logic                           req_stall,
   input  wire logic [SAMPLE_WIDTH-1:0]   req_sample_in,
   input  wire logic                      req_block_end,
   output logic                           rsp_valid,
   input  wire logic                      rsp_stall,
   output logic      [SAMPLE_WIDTH-1:0]   rsp_sample_out,
   output logic                           rsp_block_end_out,
   input  wire logic                      csr_psel,
   input  wire logic                      csr_penable,
   input  wire logic                      csr_pwrite,
   input  wire logic [CSR_ADDR_WIDTH-1:0] csr_paddr,
   input  wire logic [CSR_DATA_WIDTH-1:0] csr_pwdata,
   output logic      [CSR_DATA_WIDTH-1:0] csr_prdata,
   output logic                           csr_pready
);

   coef_set_type coefs;
   cmd_type      cmd;

   pkeq_csr #(
      .COEF_FRAC_BITS(COEF_FRAC_BITS)
   ) u_csr (
      .clock      (clock),
      .reset      (reset),
      .csr_psel   (csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite (csr_pwrite),
      .csr_paddr  (csr_paddr),
      .csr_pwdata (csr_pwdata),
      .csr_prdata (csr_prdata),
      .csr_pready (csr_pready),
      .coefs      (coefs)
   );

   pkeq_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .cmd      (cmd)
   );

   pkeq_dp #(
      .SAMPLE_WIDTH  (SAMPLE_WIDTH),
      .COEF_FRAC_BITS(COEF_FRAC_BITS),
      .STATE_WIDTH   (STATE_WIDTH)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .coefs            (coefs),
      .req_sample_in    (req_sample_in),
      .req_block_end    (req_block_end),
      .rsp_sample_out   (rsp_sample_out),
      .rsp_block_end_out(rsp_block_end_out)
   );

endmodule

`default_nettype wire
